// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked concurrent assertions with synchronous reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while reset is released
`define BGRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked while reset is released
`define BGRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/bgrc_pkg.sv -----
// ---------------------------------------------------------------------------
// bgrc_pkg
// types, codes and reset values of the battery gauge resync controller
// ---------------------------------------------------------------------------
package bgrc_pkg;

    // event kinds carried in the input tuser
    typedef enum logic [2:0] {
        FN_BEGIN   = 3'd0,
        FN_CHARGER = 3'd1,
        FN_VOLTAGE = 3'd2,
        FN_MANUAL  = 3'd3,
        FN_QSWRITE = 3'd4,
        FN_POLL    = 3'd5
    } t_func;

    // controller mode
    typedef enum logic [1:0] {
        MODE_READY   = 2'd0,
        MODE_SYNCING = 2'd1,
        MODE_ERROR   = 2'd2
    } t_mode;

    // last start reason
    typedef enum logic [1:0] {
        REASON_BOOT   = 2'd0,
        REASON_AUTO   = 2'd1,
        REASON_MANUAL = 2'd2
    } t_reason;

    // answer to a manual request
    typedef enum logic [1:0] {
        MAN_NONE    = 2'd0,
        MAN_STARTED = 2'd1,
        MAN_BUSY    = 2'd2
    } t_manual;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGER_STBL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POLL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_POLL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE      = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_VOLTAGE_STEP = 16'd100;
    localparam logic [31:0] RST_CHARGER_STBL = 32'd2000;
    localparam logic [31:0] RST_COOLDOWN     = 32'd60000;
    localparam logic [31:0] RST_FIRST_POLL   = 32'd500;
    localparam logic [31:0] RST_RETRY_POLL   = 32'd250;
    localparam logic [31:0] RST_DEADLINE     = 32'd5000;

    // input item payload, last field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic        op_succeeded;
        logic [15:0] vbat_mv;
        logic        voltage_valid;
        logic        charger_present;
        logic [31:0] now_ms;
    } t_in_data;

    // result item payload, last field in the lowest bits
    typedef struct packed {
        logic [31:0] sync_total;
        logic        poll_is_due;
        t_reason     reason_out;
        t_mode       sync_state_out;
        t_manual     manual_result;
        logic        auto_started;
    } t_out_data;

    localparam int IN_DATA_W  = $bits(t_in_data);
    localparam int OUT_DATA_W = $bits(t_out_data);

endpackage

// ----- hw/rtl/battery_gauge_resync_controller_core.sv -----
// ---------------------------------------------------------------------------
// battery gauge resync controller core
// event-driven policy that decides when the fuel gauge is resynchronized
// ---------------------------------------------------------------------------
// One event is taken per clock cycle while the output side is not stalled. An
// accepted item sits in the input register while its whole state update
// (wrapping elapsed-time compares, voltage delta, poll scheduling) is evaluated,
// and the result is written to the output register, from which it is
// presented. The state read-modify-write done in that evaluation is what sets
// the rate. The input side keeps accepting while a result waits on the output
// side, until both registers are full.
// Configuration writes take effect on the next cycle and are expected only
// while the block is idle.
module battery_gauge_resync_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bgrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    // event input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms[31:0], charger_present, voltage_valid, vbat_mv[15:0], op_succeeded, zero pad
    input  logic [bgrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func[2:0]
    input  logic [2:0]                        s_axis_tuser,
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // auto_started, manual_result[1:0], sync_state_out[1:0], reason_out[1:0],
    // poll_is_due, sync_total[31:0]
    output logic [bgrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // configuration registers
    logic [15:0] r_cfg_step;
    logic [31:0] r_cfg_stable;
    logic [31:0] r_cfg_cooldown;
    logic [31:0] r_cfg_first;
    logic [31:0] r_cfg_retry;
    logic [31:0] r_cfg_deadline;

    // pipeline registers
    logic                 r_in_valid;
    logic [2:0]           r_in_func;
    bgrc_pkg::t_in_data   r_in_data;
    logic                 r_out_valid;
    bgrc_pkg::t_out_data  r_out_data;

    // controller state
    bgrc_pkg::t_mode      r_mode, n_mode;
    bgrc_pkg::t_reason    r_reason, n_reason;
    logic                 r_chg_seen, n_chg_seen;
    logic [31:0]          r_chg_time, n_chg_time;
    logic                 r_have_prev, n_have_prev;
    logic [15:0]          r_prev_mv, n_prev_mv;
    logic                 r_have_done, n_have_done;
    logic [31:0]          r_done_time, n_done_time;
    logic [31:0]          r_begin_time, n_begin_time;
    logic [31:0]          r_next_poll, n_next_poll;
    logic [31:0]          r_count, n_count;

    logic                 s_fire;
    logic                 advance;
    logic [31:0]          now;
    logic [31:0]          el_chg, el_done, el_sync, el_poll;
    logic [31:0]          neg_first, neg_retry;
    logic [15:0]          dv;
    logic                 stable, cooled, big_step;
    logic                 auto_flag;
    bgrc_pkg::t_manual    manual;
    logic                 due;
    bgrc_pkg::t_out_data  n_out;

    // handshake
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_step     <= bgrc_pkg::RST_VOLTAGE_STEP;
            r_cfg_stable   <= bgrc_pkg::RST_CHARGER_STBL;
            r_cfg_cooldown <= bgrc_pkg::RST_COOLDOWN;
            r_cfg_first    <= bgrc_pkg::RST_FIRST_POLL;
            r_cfg_retry    <= bgrc_pkg::RST_RETRY_POLL;
            r_cfg_deadline <= bgrc_pkg::RST_DEADLINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bgrc_pkg::CFG_VOLTAGE_STEP: r_cfg_step     <= i_cfg_data[15:0];
                bgrc_pkg::CFG_CHARGER_STBL: r_cfg_stable   <= i_cfg_data;
                bgrc_pkg::CFG_COOLDOWN:     r_cfg_cooldown <= i_cfg_data;
                bgrc_pkg::CFG_FIRST_POLL:   r_cfg_first    <= i_cfg_data;
                bgrc_pkg::CFG_RETRY_POLL:   r_cfg_retry    <= i_cfg_data;
                bgrc_pkg::CFG_DEADLINE:     r_cfg_deadline <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_func <= s_axis_tuser;
            r_in_data <= bgrc_pkg::t_in_data'(s_axis_tdata);
        end
    end

    // elapsed times and voltage delta
    assign now       = r_in_data.now_ms;
    assign el_chg    = now - r_chg_time;
    assign el_done   = now - r_done_time;
    assign el_sync   = now - r_begin_time;
    assign el_poll   = now - r_next_poll;
    assign neg_first = 32'd0 - r_cfg_first;
    assign neg_retry = 32'd0 - r_cfg_retry;
    assign dv        = (r_in_data.vbat_mv > r_prev_mv) ? (r_in_data.vbat_mv - r_prev_mv)
                                                       : (r_prev_mv - r_in_data.vbat_mv);
    assign stable    = r_chg_seen && (el_chg >= r_cfg_stable);
    assign cooled    = !r_have_done || (el_done >= r_cfg_cooldown);
    assign big_step  = dv >= r_cfg_step;

    // event decode and next state
    always_comb begin
        n_mode       = r_mode;
        n_reason     = r_reason;
        n_chg_seen   = r_chg_seen;
        n_chg_time   = r_chg_time;
        n_have_prev  = r_have_prev;
        n_prev_mv    = r_prev_mv;
        n_have_done  = r_have_done;
        n_done_time  = r_done_time;
        n_begin_time = r_begin_time;
        n_next_poll  = r_next_poll;
        n_count      = r_count;
        auto_flag    = 1'b0;
        manual       = bgrc_pkg::MAN_NONE;
        due          = (r_mode == bgrc_pkg::MODE_SYNCING) && !el_poll[31];

        unique case (r_in_func)
            bgrc_pkg::FN_BEGIN: begin
                n_mode       = bgrc_pkg::MODE_READY;
                n_reason     = bgrc_pkg::REASON_BOOT;
                n_chg_seen   = 1'b0;
                n_chg_time   = now;
                n_have_prev  = 1'b0;
                n_prev_mv    = '0;
                n_have_done  = 1'b0;
                n_done_time  = now;
                n_begin_time = '0;
                n_next_poll  = '0;
                n_count      = '0;
                due          = 1'b0;
            end
            bgrc_pkg::FN_CHARGER: begin
                if (r_in_data.charger_present != r_chg_seen) begin
                    n_chg_seen  = r_in_data.charger_present;
                    n_chg_time  = now;
                    n_have_prev = 1'b0;
                end
            end
            bgrc_pkg::FN_VOLTAGE: begin
                if (r_in_data.voltage_valid && r_mode != bgrc_pkg::MODE_SYNCING) begin
                    n_prev_mv   = r_in_data.vbat_mv;
                    n_have_prev = 1'b1;
                    if (stable && r_have_prev && cooled && big_step) begin
                        auto_flag    = 1'b1;
                        n_mode       = bgrc_pkg::MODE_SYNCING;
                        n_reason     = bgrc_pkg::REASON_AUTO;
                        n_begin_time = now;
                        n_next_poll  = now + r_cfg_first;
                        due          = !neg_first[31];
                    end
                end
            end
            bgrc_pkg::FN_MANUAL: begin
                if (r_mode == bgrc_pkg::MODE_SYNCING) begin
                    manual = bgrc_pkg::MAN_BUSY;
                end else begin
                    manual       = bgrc_pkg::MAN_STARTED;
                    n_mode       = bgrc_pkg::MODE_SYNCING;
                    n_reason     = bgrc_pkg::REASON_MANUAL;
                    n_begin_time = now;
                    n_next_poll  = now + r_cfg_first;
                    due          = !neg_first[31];
                end
            end
            bgrc_pkg::FN_QSWRITE: begin
                if (r_mode == bgrc_pkg::MODE_SYNCING && !r_in_data.op_succeeded) begin
                    n_mode      = bgrc_pkg::MODE_ERROR;
                    n_next_poll = '0;
                    n_have_done = 1'b1;
                    n_done_time = now;
                    due         = 1'b0;
                end
            end
            bgrc_pkg::FN_POLL: begin
                if (r_mode == bgrc_pkg::MODE_SYNCING) begin
                    if (r_in_data.op_succeeded) begin
                        n_mode      = bgrc_pkg::MODE_READY;
                        n_next_poll = '0;
                        n_have_done = 1'b1;
                        n_done_time = now;
                        n_count     = r_count + 32'd1;
                        due         = 1'b0;
                    end else if (el_sync >= r_cfg_deadline) begin
                        n_mode      = bgrc_pkg::MODE_ERROR;
                        n_next_poll = '0;
                        n_have_done = 1'b1;
                        n_done_time = now;
                        due         = 1'b0;
                    end else begin
                        n_next_poll = now + r_cfg_retry;
                        due         = !neg_retry[31];
                    end
                end
            end
            default: ;
        endcase

        n_out.auto_started   = auto_flag;
        n_out.manual_result  = manual;
        n_out.sync_state_out = n_mode;
        n_out.reason_out     = n_reason;
        n_out.poll_is_due    = due;
        n_out.sync_total     = n_count;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= bgrc_pkg::MODE_READY;
            r_reason    <= bgrc_pkg::REASON_BOOT;
            r_chg_seen  <= 1'b0;
            r_have_prev <= 1'b0;
            r_have_done <= 1'b0;
            r_count     <= '0;
        end else if (advance) begin
            r_mode      <= n_mode;
            r_reason    <= n_reason;
            r_chg_seen  <= n_chg_seen;
            r_have_prev <= n_have_prev;
            r_have_done <= n_have_done;
            r_count     <= n_count;
        end
    end

    // timestamps and samples, only read under their flags
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_chg_time   <= n_chg_time;
            r_prev_mv    <= n_prev_mv;
            r_done_time  <= n_done_time;
            r_begin_time <= n_begin_time;
            r_next_poll  <= n_next_poll;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out;
        end
    end

endmodule

// ----- hw/rtl/bgrc_checker.sv -----
// ---------------------------------------------------------------------------
// bgrc checker
// port-level checks on the result stream of the resync controller
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bgrc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bgrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    bgrc_pkg::t_out_data res;
    logic                is_syncing;
    logic                out_stall;
    logic                auto_seen, auto_ok;
    logic                man_seen, man_ok;
    logic                due_seen;

    assign res        = bgrc_pkg::t_out_data'(m_axis_tdata);
    assign is_syncing = res.sync_state_out == bgrc_pkg::MODE_SYNCING;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign auto_seen  = m_axis_tvalid && res.auto_started;
    assign auto_ok    = is_syncing && res.reason_out == bgrc_pkg::REASON_AUTO &&
                        res.manual_result == bgrc_pkg::MAN_NONE;
    assign man_seen   = m_axis_tvalid && res.manual_result == bgrc_pkg::MAN_STARTED;
    assign man_ok     = is_syncing && res.reason_out == bgrc_pkg::REASON_MANUAL;
    assign due_seen   = m_axis_tvalid && res.poll_is_due;

    // a stalled item holds
    `BGRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // an automatic start leaves the block syncing for the automatic reason, with no manual result
    `BGRC_ASSERT_SAME(a_auto_sync, i_clk, i_rst_n, auto_seen, auto_ok)

    // a manual start leaves the block syncing for the manual reason
    `BGRC_ASSERT_SAME(a_manual_sync, i_clk, i_rst_n, man_seen, man_ok)

    // a poll can only be due while syncing
    `BGRC_ASSERT_SAME(a_due_sync, i_clk, i_rst_n, due_seen, is_syncing)

endmodule

bind battery_gauge_resync_controller_core bgrc_checker u_bgrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
